// File: hw/rtl/itf_pkg.sv
// ----------------------------------------------------------------------------
// itf_pkg: shared types, constants and functions of the 4x4 inverse transform
// Holds the block geometry, the configuration register codes, the sequencer
// state type, the butterfly arithmetic and the store addressing.
// ----------------------------------------------------------------------------
`default_nettype none

package itf_pkg;

  // Block geometry.
  localparam int BLOCK_DIM = 4;
  localparam int NCOEF     = BLOCK_DIM * BLOCK_DIM;
  localparam int IDX_W     = $clog2(NCOEF);
  localparam int LANE_W    = $clog2(BLOCK_DIM);
  localparam int GRP_W     = $clog2(2 * BLOCK_DIM);

  // Field widths. Column results of 18-bit coefficients fit in 22 bits.
  localparam int COEF_W    = 18;
  localparam int ACC_W     = 22;
  localparam int TDATA_W   = 24;

  // Configuration port.
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 4;
  localparam logic [CFG_IDX_W-1:0] REG_BIT_DEPTH  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ROUND_MODE = 1'd1;
  localparam logic [3:0] BIT_DEPTH_RESET  = 4'd8;
  localparam logic       ROUND_MODE_RESET = 1'b1;

  typedef logic signed [ACC_W-1:0] acc_t;
  typedef acc_t [BLOCK_DIM-1:0]    acc4_t;

  // Configuration in force, as seen by the output stage.
  typedef struct packed {
    logic [3:0] bit_depth;
    logic       round_mode;
  } cfg_t;

  typedef enum logic [1:0] {
    ST_LOAD,
    ST_GATHER,
    ST_SCATTER,
    ST_DRAIN
  } state_t;

  // One 4-point butterfly with half-shifted odd terms. Values are known to fit
  // in ACC_W bits, so wrap in the intermediates does not change the result.
  function automatic acc4_t butterfly(input acc4_t t);
    acc_t  p0;
    acc_t  p1;
    acc_t  p2;
    acc_t  p3;
    acc4_t o;
    p0 = t[0] + t[2];
    p1 = t[0] - t[2];
    p2 = (t[1] >>> 1) - t[3];
    p3 = t[1] + (t[3] >>> 1);
    o[0] = p0 + p3;
    o[1] = p1 + p2;
    o[2] = p1 - p2;
    o[3] = p0 - p3;
    return o;
  endfunction

  // Store address of element elem of group grp. Groups below BLOCK_DIM are
  // rows, the others are columns.
  function automatic logic [IDX_W-1:0] addr_of(input logic [GRP_W-1:0]  grp,
                                                input logic [LANE_W-1:0] elem);
    logic [IDX_W-1:0] a;
    if (grp[GRP_W-1]) begin
      a = {elem, grp[LANE_W-1:0]};
    end else begin
      a = {grp[LANE_W-1:0], elem};
    end
    return a;
  endfunction

endpackage

`default_nettype wire

// File: hw/rtl/itf_ram.sv
// ----------------------------------------------------------------------------
// itf_ram: simple dual-port synchronous RAM
// One write port and one read port; read data is registered.
// ----------------------------------------------------------------------------
`default_nettype none

module itf_ram #(
  parameter int DEPTH = 16,
  parameter int WIDTH = 22,
  parameter int AW    = $clog2(DEPTH)
) (
  input  wire logic             clk,
  input  wire logic             wr_en,
  input  wire logic [AW-1:0]    wr_addr,
  input  wire logic [WIDTH-1:0] wr_data,
  input  wire logic             rd_en,
  input  wire logic [AW-1:0]    rd_addr,
  output logic      [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/itf_post.sv
// ----------------------------------------------------------------------------
// itf_post: output rounding and saturation
// Rounds and shifts a column result and clips it to the bit-depth range, or
// in raw mode clips it unshifted to the wide range.
// ----------------------------------------------------------------------------
`default_nettype none

module itf_post (
  input  wire itf_pkg::cfg_t                       cfg,
  input  wire logic signed [itf_pkg::ACC_W-1:0]    din,
  output logic signed      [itf_pkg::COEF_W-1:0]   dout
);

  localparam int SW = itf_pkg::ACC_W + 1;

  logic [3:0]           depth;
  logic                 is_d8;
  logic signed [SW-1:0] din_x;
  logic signed [SW-1:0] rnd_sum;
  logic signed [SW-1:0] shifted;
  logic signed [SW-1:0] val;
  logic [4:0]           exp_w;
  logic signed [SW-1:0] lim_pos;
  logic signed [SW-1:0] hi;
  logic signed [SW-1:0] lo;
  logic signed [SW-1:0] sat;

  // Bit depth is held to the range 8 to 12.
  always_comb begin
    priority if (cfg.bit_depth < 4'd8) begin
      depth = 4'd8;
    end else if (cfg.bit_depth > 4'd12) begin
      depth = 4'd12;
    end else begin
      depth = cfg.bit_depth;
    end
  end

  assign is_d8 = (depth == 4'd8);

  // Round and shift: by 6 at 8-bit depth, by 5 otherwise.
  assign din_x   = SW'(din);
  assign rnd_sum = din_x + (is_d8 ? SW'(32) : SW'(16));
  assign shifted = is_d8 ? (rnd_sum >>> 6) : (rnd_sum >>> 5);

  // Select value and clip exponent for the mode.
  always_comb begin
    if (cfg.round_mode) begin
      val   = shifted;
      exp_w = {1'b0, depth};
    end else begin
      val   = din_x;
      exp_w = is_d8 ? 5'd14 : ({1'b0, depth} + 5'd5);
    end
  end

  assign lim_pos = SW'(1) <<< exp_w;
  assign hi      = lim_pos - SW'(1);
  assign lo      = -lim_pos;

  // Saturate to the signed range.
  always_comb begin
    priority if (val > hi) begin
      sat = hi;
    end else if (val < lo) begin
      sat = lo;
    end else begin
      sat = val;
    end
  end

  assign dout = sat[itf_pkg::COEF_W-1:0];

endmodule

`default_nettype wire

// File: hw/rtl/inverse_transform_4x4_unit.sv
// ----------------------------------------------------------------------------
// inverse_transform_4x4_unit: streaming 4x4 inverse integer transform
// Loads 16 coefficients into a RAM, runs row then column butterflies in place
// through the RAM, and streams out 16 rounded and clipped residuals.
// ----------------------------------------------------------------------------
//
//   Channel  | Ports                         | Content
//   ---------+-------------------------------+--------------------------------
//   input    | in_tvalid/in_tready/in_tdata  | one coefficient per request
//   output   | out_tvalid/out_tready/out_*   | residual, tlast on sample 16
//   config   | cfg_wr_en/cfg_index/cfg_wdata | 0 bit depth, 1 round/clip mode
//
// Coefficients are taken one per cycle while loading. The transform then runs 8
// butterfly groups, each reading and rewriting four values, paced by the single
// read and single write port of the store RAM. Output reads one sample at a time,
// only while no read is in flight and the output register will be free. A new
// block is accepted as soon as the last sample sits in the output register. Output
// stalls hold the drain; reset is synchronous and the RAM needs no clearing.
// ----------------------------------------------------------------------------
`default_nettype none

module inverse_transform_4x4_unit (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  // Coefficient stream.
  input  wire logic                                in_tvalid,
  output logic                                     in_tready,
  input  wire logic [itf_pkg::TDATA_W-1:0]         in_tdata,   // [17:0] coefficient
  // Residual stream.
  output logic                                     out_tvalid,
  input  wire logic                                out_tready,
  output logic      [itf_pkg::TDATA_W-1:0]         out_tdata,  // [17:0] residual
  output logic                                     out_tlast,
  // Configuration write port.
  input  wire logic                                cfg_wr_en,
  input  wire logic [itf_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  wire logic [itf_pkg::CFG_DATA_W-1:0]      cfg_wdata
);

  localparam int IDX_W  = itf_pkg::IDX_W;
  localparam int LANE_W = itf_pkg::LANE_W;
  localparam int GRP_W  = itf_pkg::GRP_W;
  localparam int ACC_W  = itf_pkg::ACC_W;
  localparam int COEF_W = itf_pkg::COEF_W;
  localparam logic [IDX_W-1:0]  LAST_IDX  = IDX_W'(itf_pkg::NCOEF - 1);
  localparam logic [LANE_W-1:0] LAST_LANE = LANE_W'(itf_pkg::BLOCK_DIM - 1);
  localparam logic [GRP_W-1:0]  LAST_GRP  = GRP_W'(2 * itf_pkg::BLOCK_DIM - 1);

  itf_pkg::state_t state_r, state_nxt;
  itf_pkg::cfg_t   cfg_r;

  logic [IDX_W-1:0]  cnt_r;
  logic [GRP_W-1:0]  grp_r;
  logic [LANE_W-1:0] elem_r;
  logic              rd_vld_r;
  logic [LANE_W-1:0] rd_lane_r;
  logic [IDX_W-1:0]  rd_idx_r;
  itf_pkg::acc4_t    gath_r;
  itf_pkg::acc4_t    bfly;

  logic              out_vld_r;
  logic [COEF_W-1:0] out_data_r;
  logic              out_last_r;

  logic              in_fire;
  logic              out_fire;
  logic              gather_issue;
  logic              drain_issue;
  logic              drain_load;

  logic              ram_wr_en;
  logic [IDX_W-1:0]  ram_wr_addr;
  logic [ACC_W-1:0]  ram_wr_data;
  logic              ram_rd_en;
  logic [IDX_W-1:0]  ram_rd_addr;
  logic [ACC_W-1:0]  ram_rd_data;
  logic signed [COEF_W-1:0] post_q;

  assign in_fire  = in_tvalid && in_tready;
  assign out_fire = out_vld_r && out_tready;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.bit_depth  <= itf_pkg::BIT_DEPTH_RESET;
      cfg_r.round_mode <= itf_pkg::ROUND_MODE_RESET;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        itf_pkg::REG_BIT_DEPTH:  cfg_r.bit_depth  <= cfg_wdata;
        itf_pkg::REG_ROUND_MODE: cfg_r.round_mode <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // Butterfly over the gathered group.
  assign bfly = itf_pkg::butterfly(gath_r);

  // Sequencer next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      itf_pkg::ST_LOAD: begin
        if (in_fire && cnt_r == LAST_IDX) begin
          state_nxt = itf_pkg::ST_GATHER;
        end
      end
      itf_pkg::ST_GATHER: begin
        if (rd_vld_r && rd_lane_r == LAST_LANE) begin
          state_nxt = itf_pkg::ST_SCATTER;
        end
      end
      itf_pkg::ST_SCATTER: begin
        if (elem_r == LAST_LANE) begin
          state_nxt = (grp_r == LAST_GRP) ? itf_pkg::ST_DRAIN : itf_pkg::ST_GATHER;
        end
      end
      itf_pkg::ST_DRAIN: begin
        if (rd_vld_r && rd_idx_r == LAST_IDX) begin
          state_nxt = itf_pkg::ST_LOAD;
        end
      end
      default: state_nxt = itf_pkg::ST_LOAD;
    endcase
  end

  // Sequencer outputs: RAM port control and handshake.
  always_comb begin
    in_tready    = 1'b0;
    ram_wr_en    = 1'b0;
    ram_wr_addr  = cnt_r;
    ram_wr_data  = ACC_W'($signed(in_tdata[COEF_W-1:0]));
    ram_rd_en    = 1'b0;
    ram_rd_addr  = cnt_r;
    gather_issue = 1'b0;
    drain_issue  = 1'b0;
    unique case (state_r)
      itf_pkg::ST_LOAD: begin
        in_tready = 1'b1;
        ram_wr_en = in_fire;
      end
      itf_pkg::ST_GATHER: begin
        // Stop issuing once the last lane's read is in flight.
        gather_issue = !(rd_vld_r && rd_lane_r == LAST_LANE);
        ram_rd_en    = gather_issue;
        ram_rd_addr  = itf_pkg::addr_of(grp_r, elem_r);
      end
      itf_pkg::ST_SCATTER: begin
        ram_wr_en   = 1'b1;
        ram_wr_addr = itf_pkg::addr_of(grp_r, elem_r);
        ram_wr_data = bfly[elem_r];
      end
      itf_pkg::ST_DRAIN: begin
        // Read only when the output register is free by the time data lands.
        drain_issue = !rd_vld_r && (!out_vld_r || out_fire);
        ram_rd_en   = drain_issue;
      end
      default: ;
    endcase
  end

  assign drain_load = (state_r == itf_pkg::ST_DRAIN) && rd_vld_r;

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= itf_pkg::ST_LOAD;
      cnt_r     <= '0;
      grp_r     <= '0;
      elem_r    <= '0;
      rd_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      rd_vld_r <= gather_issue || drain_issue;
      if (in_fire || drain_issue) begin
        cnt_r <= cnt_r + IDX_W'(1);
      end
      if (gather_issue || state_r == itf_pkg::ST_SCATTER) begin
        elem_r <= elem_r + LANE_W'(1);
      end
      if (state_r == itf_pkg::ST_SCATTER && elem_r == LAST_LANE) begin
        grp_r <= grp_r + GRP_W'(1);
      end
      if (drain_load) begin
        out_vld_r <= 1'b1;
      end else if (out_fire) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  // Payload registers: read tags, gathered group and output sample.
  always_ff @(posedge clk) begin
    if (gather_issue || drain_issue) begin
      rd_lane_r <= elem_r;
      rd_idx_r  <= ram_rd_addr;
    end
    if (state_r == itf_pkg::ST_GATHER && rd_vld_r) begin
      gath_r[rd_lane_r] <= ram_rd_data;
    end
    if (drain_load) begin
      out_data_r <= post_q;
      out_last_r <= (rd_idx_r == LAST_IDX);
    end
  end

  // Coefficient and intermediate store.
  itf_ram #(
    .DEPTH (itf_pkg::NCOEF),
    .WIDTH (ACC_W)
  ) u_store (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .rd_en   (ram_rd_en),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_rd_data)
  );

  // Output rounding and clipping.
  itf_post u_post (
    .cfg  (cfg_r),
    .din  (ram_rd_data),
    .dout (post_q)
  );

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {(itf_pkg::TDATA_W - COEF_W)'(0), out_data_r};
  assign out_tlast  = out_last_r;

`ifndef ASSERT_OFF
  // A drained sample never lands on a full output register.
  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == itf_pkg::ST_DRAIN && rd_vld_r) |-> !out_vld_r)
    else $error("output register overrun");

  // The sixteenth coefficient starts the first row group.
  a_start_rows: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && cnt_r == LAST_IDX) |=> (state_r == itf_pkg::ST_GATHER && grp_r == '0))
    else $error("transform did not start at first row");

  // After the last sample is taken the block is loading again.
  a_last_load: assert property (@(posedge clk) disable iff (!rst_n)
    (out_fire && out_last_r) |=> (state_r == itf_pkg::ST_LOAD))
    else $error("block not back in load after last sample");
`endif

endmodule

`default_nettype wire

// File: test/inverse_transform_4x4_unit_test.sv
// ----------------------------------------------------------------------------
// inverse_transform_4x4_unit_test: self-checking bench for the 4x4 transform
// Streams 4x4 coefficient blocks into the unit and checks every residual
// sample and its end-of-block flag. Expected samples come from a predictor of
// the row and column butterflies with rounding and clipping. A directed
// table runs first, followed by random blocks under changing bit depths and
// modes, with random stalls on both streams.
// ----------------------------------------------------------------------------

module inverse_transform_4x4_unit_test;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int NCOEF         = itf_pkg::NCOEF;
  localparam int COEF_W        = itf_pkg::COEF_W;
  localparam int TDATA_W       = itf_pkg::TDATA_W;
  localparam int NUM_ROWS      = 16;
  localparam int RANDOM_BLOCKS = 4;
  localparam int SETTLE_CYCLES = 8;
  localparam int TAIL_CYCLES   = 130;
  localparam int STUCK_LIMIT   = 2000;
  localparam int PRINT_LIMIT   = 200;

  localparam logic [COEF_W-1:0] COEF_MAX = 18'h1FFFF;
  localparam logic [COEF_W-1:0] COEF_MIN = 18'h20000;

  // How a directed block is filled.
  typedef enum logic [2:0] {
    FILL_ZERO,
    FILL_DC,
    FILL_FLAT,
    FILL_CHECKER,
    FILL_RANDOM
  } fill_t;

  // One row of the directed table.
  typedef struct packed {
    logic                             keep_cfg;
    logic [itf_pkg::CFG_DATA_W-1:0]   depth_wdata;
    logic [itf_pkg::CFG_DATA_W-1:0]   mode_wdata;
    fill_t                            fill;
    logic [COEF_W-1:0]                value;
    logic                             typed;
    logic [COEF_W-1:0]                typed_residual;
  } block_plan_t;

  // One expected residual sample.
  typedef struct packed {
    logic [COEF_W-1:0] residual;
    logic              last;
  } sample_t;

  logic                              clk        = 1'b0;
  logic                              rst_n      = 1'b0;
  logic                              in_tvalid  = 1'b0;
  logic                              in_tready;
  logic [TDATA_W-1:0]                in_tdata   = '0;
  logic                              out_tvalid;
  logic                              out_tready = 1'b0;
  logic [TDATA_W-1:0]                out_tdata;
  logic                              out_tlast;
  logic                              cfg_wr_en  = 1'b0;
  logic [itf_pkg::CFG_IDX_W-1:0]     cfg_index  = '0;
  logic [itf_pkg::CFG_DATA_W-1:0]    cfg_wdata  = '0;

  // Predictor state: configuration copy, coefficient store and load count.
  logic [3:0]  cur_depth = 4'd8;
  logic        cur_mode  = 1'b1;
  int          coef_store [NCOEF];
  int          coef_count = 0;
  logic        typed_on = 1'b0;
  logic [COEF_W-1:0] typed_value = '0;

  sample_t     expected_residuals [$];
  sample_t     head_sample;
  int          mismatch_count = 0;
  int          sample_count = 0;
  int          stuck_cycles = 0;
  int          stall_left = 0;
  bit          idle_en = 1'b1;

  inverse_transform_4x4_unit dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),    // [17:0] coefficient
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),   // [17:0] residual
    .out_tlast  (out_tlast),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  // Clock with a 4 ns period.
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  task automatic report_mismatch(input string msg);
    if (mismatch_count < PRINT_LIMIT) begin
      $display("MISMATCH: %s", msg);
    end
    mismatch_count++;
  endtask

  // Four-point butterfly with half-shifted odd terms; >>> floors on int.
  function automatic void butterfly4(input int t0, input int t1, input int t2, input int t3,
                                     output int o0, output int o1, output int o2,
                                     output int o3);
    int p0;
    int p1;
    int p2;
    int p3;
    p0 = t0 + t2;
    p1 = t0 - t2;
    p2 = (t1 >>> 1) - t3;
    p3 = t1 + (t3 >>> 1);
    o0 = p0 + p3;
    o1 = p1 + p2;
    o2 = p1 - p2;
    o3 = p0 - p3;
  endfunction

  // Transform the held block and queue its 16 samples in raster order.
  task automatic inverse_transform_block();
    int rows [NCOEF];
    int col [4];
    logic [COEF_W-1:0] res [NCOEF];
    int d;
    int s;
    int lim;
    int v;
    sample_t smp;
    d = int'(cur_depth);
    if (d < 8) d = 8;
    if (d > 12) d = 12;
    for (int i = 0; i < 4; i++) begin
      butterfly4(coef_store[i*4], coef_store[i*4+1], coef_store[i*4+2], coef_store[i*4+3],
                 rows[i*4], rows[i*4+1], rows[i*4+2], rows[i*4+3]);
    end
    for (int i = 0; i < 4; i++) begin
      butterfly4(rows[i], rows[4+i], rows[8+i], rows[12+i], col[0], col[1], col[2], col[3]);
      for (int r = 0; r < 4; r++) begin
        if (cur_mode) begin
          s   = (d == 8) ? 6 : 5;
          lim = 1 << d;
          v   = (col[r] + (1 << (s - 1))) >>> s;
        end else begin
          lim = 1 << ((d == 8) ? 14 : d + 5);
          v   = col[r];
        end
        if (v < -lim) v = -lim;
        if (v > lim - 1) v = lim - 1;
        res[r*4+i] = v[COEF_W-1:0];
      end
    end
    for (int k = 0; k < NCOEF; k++) begin
      smp.residual = typed_on ? typed_value : res[k];
      smp.last     = (k == NCOEF - 1);
      expected_residuals.push_back(smp);
    end
  endtask

  // Hold one accepted coefficient; the sixteenth completes the block.
  task automatic take_coefficient(input logic [COEF_W-1:0] c);
    coef_store[coef_count] = int'($signed(c));
    coef_count++;
    if (coef_count == NCOEF) begin
      coef_count = 0;
      inverse_transform_block();
    end
  endtask

  // Offer one coefficient, possibly after an idle burst, until it is taken.
  task automatic send_coefficient(input logic [COEF_W-1:0] c);
    int gap;
    if (idle_en && $urandom_range(5) == 0) begin
      gap = $urandom_range(14, 1);
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {{(TDATA_W - COEF_W){1'b0}}, c};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    take_coefficient(c);
  endtask

  // Stop offering and wait until every expected sample has been taken.
  task automatic drain_block_results();
    in_tvalid <= 1'b0;
    while (expected_residuals.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Write the bit depth register, then the round mode register, back to back.
  task automatic set_config(input logic [itf_pkg::CFG_DATA_W-1:0] depth_wdata,
                            input logic [itf_pkg::CFG_DATA_W-1:0] mode_wdata);
    cfg_wr_en <= 1'b1;
    cfg_index <= itf_pkg::REG_BIT_DEPTH;
    cfg_wdata <= depth_wdata;
    @(posedge clk);
    cur_depth = depth_wdata;
    cfg_index <= itf_pkg::REG_ROUND_MODE;
    cfg_wdata <= mode_wdata;
    @(posedge clk);
    cur_mode = mode_wdata[0];
    cfg_wr_en <= 1'b0;
  endtask

  // Directed table. Expected samples are typed in only for plain cases.
  function automatic block_plan_t directed_plan(input int row);
    block_plan_t p;
    case (row)
      // After reset: default depth 8 with rounding.
      0:  p = '{1'b1, 4'd8,  4'd1,  FILL_ZERO,    18'h0,    1'b1, 18'h00000};
      1:  p = '{1'b1, 4'd8,  4'd1,  FILL_DC,      COEF_MAX, 1'b1, 18'h000FF};
      2:  p = '{1'b1, 4'd8,  4'd1,  FILL_DC,      COEF_MIN, 1'b1, 18'h3FF00};
      3:  p = '{1'b1, 4'd8,  4'd1,  FILL_FLAT,    COEF_MAX, 1'b0, 18'h0};
      4:  p = '{1'b1, 4'd8,  4'd1,  FILL_FLAT,    COEF_MIN, 1'b0, 18'h0};
      5:  p = '{1'b1, 4'd8,  4'd1,  FILL_CHECKER, COEF_MAX, 1'b0, 18'h0};
      // Clip-only mode at the narrowest and widest ranges.
      6:  p = '{1'b0, 4'd8,  4'd0,  FILL_DC,      COEF_MAX, 1'b1, 18'h03FFF};
      7:  p = '{1'b0, 4'd8,  4'd0,  FILL_DC,      COEF_MIN, 1'b1, 18'h3C000};
      8:  p = '{1'b0, 4'd12, 4'd0,  FILL_DC,      COEF_MAX, 1'b1, 18'h1FFFF};
      9:  p = '{1'b0, 4'd12, 4'd0,  FILL_DC,      COEF_MIN, 1'b1, 18'h20000};
      // Bit depths outside 8..12 act as the nearest end, mixed with in-range depths.
      10: p = '{1'b0, 4'd3,  4'd1,  FILL_DC,      COEF_MAX, 1'b1, 18'h000FF};
      11: p = '{1'b0, 4'd15, 4'd1,  FILL_DC,      COEF_MAX, 1'b1, 18'h00FFF};
      12: p = '{1'b0, 4'd10, 4'd1,  FILL_RANDOM,  18'h0,    1'b0, 18'h0};
      13: p = '{1'b0, 4'd0,  4'd14, FILL_CHECKER, COEF_MIN, 1'b0, 18'h0};
      14: p = '{1'b0, 4'd12, 4'd1,  FILL_CHECKER, COEF_MAX, 1'b0, 18'h0};
      default: p = '{1'b0, 4'd9, 4'd0, FILL_FLAT, COEF_MIN, 1'b0, 18'h0};
    endcase
    return p;
  endfunction

  function automatic logic [COEF_W-1:0] plan_coefficient(input block_plan_t p, input int pos);
    logic [COEF_W-1:0] c;
    case (p.fill)
      FILL_DC:      c = (pos == 0) ? p.value : '0;
      FILL_FLAT:    c = p.value;
      FILL_CHECKER: c = (((pos / 4) + (pos % 4)) % 2 == 1) ? ~p.value : p.value;
      FILL_RANDOM:  c = COEF_W'($urandom());
      default:      c = '0;
    endcase
    return c;
  endfunction

  // Random coefficient in one of several styles; style 4 mixes them.
  function automatic logic [COEF_W-1:0] random_coefficient(input int style);
    int v;
    logic [COEF_W-1:0] c;
    if (style == 4) style = $urandom_range(3);
    case (style)
      0: c = COEF_W'($urandom());
      1: begin
        v = int'($urandom_range(255)) - 128;
        c = ($urandom_range(3) == 0) ? v[COEF_W-1:0] : '0;
      end
      2: begin
        case ($urandom_range(4))
          0: c = COEF_MAX;
          1: c = COEF_MIN;
          2: c = 18'h3FFFF;
          3: c = 18'h00001;
          default: c = '0;
        endcase
      end
      default: begin
        v = int'($urandom_range(8191)) - 4096;
        c = v[COEF_W-1:0];
      end
    endcase
    return c;
  endfunction

  // Residual sink: ready, with random stall bursts while idling is on.
  always @(posedge clk) begin
    if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      out_tready <= (stall_left == 1);
    end else if (idle_en && $urandom_range(7) == 0) begin
      stall_left <= $urandom_range(14, 1);
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  // Compare each taken sample with the oldest expectation.
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_residuals.size() == 0) begin
        report_mismatch($sformatf("sample %0d: residual %h last %b with none expected",
                                  sample_count, out_tdata[COEF_W-1:0], out_tlast));
      end else begin
        head_sample = expected_residuals.pop_front();
        if (out_tdata[COEF_W-1:0] !== head_sample.residual || out_tlast !== head_sample.last) begin
          report_mismatch($sformatf("sample %0d: residual %h want %h, last %b want %b",
                                    sample_count, out_tdata[COEF_W-1:0],
                                    head_sample.residual, out_tlast, head_sample.last));
        end
      end
      sample_count++;
    end
  end

  // Watchdog on cycles in which no request of any kind is taken.
  always @(posedge clk) begin
    if (!rst_n || cfg_wr_en || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      stuck_cycles <= 0;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
      if (stuck_cycles >= STUCK_LIMIT) begin
        $display("inverse_transform_4x4_unit_test: done, errors");
        $finish;
      end
    end
  end

  // Main sequence: reset, directed table, random phases, final drain.
  initial begin
    block_plan_t plan;
    int blk_done;
    int n_blk;
    int style;
    logic [3:0] depth_w;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    idle_en = 1'b1;
    for (int r = 0; r < NUM_ROWS; r++) begin
      plan = directed_plan(r);
      if (!plan.keep_cfg) begin
        drain_block_results();
        set_config(plan.depth_wdata, plan.mode_wdata);
      end
      typed_on    = plan.typed;
      typed_value = plan.typed_residual;
      for (int p = 0; p < NCOEF; p++) begin
        send_coefficient(plan_coefficient(plan, p));
      end
    end
    typed_on = 1'b0;

    // Random phases; the last few blocks run without idling.
    blk_done = 0;
    while (blk_done < RANDOM_BLOCKS) begin
      drain_block_results();
      n_blk   = $urandom_range(3, 1);
      if (blk_done + n_blk > RANDOM_BLOCKS) n_blk = RANDOM_BLOCKS - blk_done;
      idle_en = (blk_done + n_blk <= RANDOM_BLOCKS - 3) ? ($urandom_range(3) != 0) : 1'b0;
      if ($urandom_range(3) == 0) begin
        depth_w = 4'($urandom_range(15));
      end else begin
        depth_w = 4'($urandom_range(12, 8));
      end
      set_config(depth_w, 4'($urandom_range(15)));
      repeat (n_blk) begin
        style = $urandom_range(4);
        for (int p = 0; p < NCOEF; p++) begin
          send_coefficient(random_coefficient(style));
        end
        blk_done++;
      end
    end

    drain_block_results();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (expected_residuals.size() != 0) begin
      report_mismatch($sformatf("%0d expected samples never arrived",
                                expected_residuals.size()));
    end
    if (mismatch_count == 0) begin
      $display("inverse_transform_4x4_unit_test: done, clean");
    end else begin
      $display("inverse_transform_4x4_unit_test: done, errors");
    end
    $finish;
  end

endmodule

// File: files.f
hw/rtl/itf_pkg.sv
hw/rtl/itf_ram.sv
hw/rtl/itf_post.sv
hw/rtl/inverse_transform_4x4_unit.sv
test/inverse_transform_4x4_unit_test.sv
